>>> src/ppp_pkg.sv
// perspective point projection: shared constants and types
// no dependencies
`default_nettype none
package ppp_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TAG_BITS  = 24;
  localparam int MAG_BITS  = 2 * WORD_BITS;
  localparam int QBITS     = WORD_BITS + 1;
  localparam int DIV_LAT   = QBITS + 1;
  localparam int IDX_BITS  = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_X_SCALE  = 3'd0,
    REG_X_OFFSET = 3'd1,
    REG_Y_SCALE  = 3'd2,
    REG_Y_OFFSET = 3'd3,
    REG_DEPTH_A  = 3'd4,
    REG_DEPTH_B  = 3'd5
  } cfg_reg_t;
endpackage
`default_nettype wire

>>> src/ppp_if.sv
// valid/ready channels for vertex words and projected words
// depends on ppp_pkg
`default_nettype none
interface ppp_in_if;
  logic              valid;
  logic              ready;
  ppp_pkg::word_t    eye_x;
  ppp_pkg::word_t    eye_y;
  ppp_pkg::word_t    eye_z;
  ppp_pkg::tag_t     vertex_id;
  modport source (output valid, eye_x, eye_y, eye_z, vertex_id, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, vertex_id, output ready);
endinterface

interface ppp_out_if;
  logic              valid;
  logic              ready;
  ppp_pkg::tag_t     vertex_tag;
  ppp_pkg::word_t    screen_x;
  ppp_pkg::word_t    screen_y;
  ppp_pkg::word_t    ndc_depth;
  logic              zero_w;
  logic              clipped;
  modport source (output valid, vertex_tag, screen_x, screen_y, ndc_depth, zero_w,
                  clipped, input ready);
  modport sink (input valid, vertex_tag, screen_x, screen_y, ndc_depth, zero_w,
                clipped, output ready);
endinterface
`default_nettype wire

>>> src/ppp_div_lane.sv
// pipelined restoring divider lane, one quotient bit per stage
// depends on ppp_pkg
`default_nettype none
module ppp_div_lane (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ppp_pkg::MAG_BITS-1:0]  mag,
  input  wire logic [ppp_pkg::WORD_BITS-1:0] dvs,
  output logic      [ppp_pkg::QBITS-1:0]     quot,
  output logic                               ovf
);
  import ppp_pkg::*;

  logic [WORD_BITS-1:0] rem_s [0:QBITS];
  logic [QBITS-1:0]     low_s [0:QBITS];
  logic [QBITS-1:0]     q_s   [0:QBITS];
  logic [WORD_BITS-1:0] d_s   [0:QBITS];
  logic                 ovf_s [0:QBITS];
  logic [WORD_BITS-1:0] top;

  assign top = {1'b0, mag[MAG_BITS-1:QBITS]};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= top;
      low_s[0] <= mag[QBITS-1:0];
      q_s[0]   <= '0;
      d_s[0]   <= dvs;
      ovf_s[0] <= (top >= dvs);
    end
  end

  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic [WORD_BITS:0] t;
    logic [WORD_BITS:0] diff;
    logic               ge;
    assign t    = {rem_s[k-1], low_s[k-1][QBITS-1]};
    assign diff = t - {1'b0, d_s[k-1]};
    assign ge   = (t >= {1'b0, d_s[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? diff[WORD_BITS-1:0] : t[WORD_BITS-1:0];
        low_s[k] <= {low_s[k-1][QBITS-2:0], 1'b0};
        q_s[k]   <= {q_s[k-1][QBITS-2:0], ge};
        d_s[k]   <= d_s[k-1];
        ovf_s[k] <= ovf_s[k-1];
      end
    end
  end

  assign quot = q_s[QBITS];
  assign ovf  = ovf_s[QBITS];
endmodule
`default_nettype wire

>>> src/perspective_point_projection.sv
// Projects one eye-space vertex per cycle, unless the output stalls, to screen
// x, y and depth by a divide by w = -eye_z. Stages in order: input register,
// multiply, numerator sum, magnitude, 34 divider stages (a load stage, then one
// quotient bit each) and the saturating output register. The whole pipeline
// advances whenever the output register is empty or taken, so one word enters
// each cycle that it advances. The user writes coefficients (cfg_we/cfg_index/
// cfg_data) only while no word is in flight; the block does not enforce it.
// depends on ppp_pkg, ppp_if, ppp_div_lane
`default_nettype none
module perspective_point_projection (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ppp_pkg::IDX_BITS-1:0] cfg_index,
  input  wire ppp_pkg::word_t               cfg_data,
  ppp_in_if.sink                            in_ch,
  ppp_out_if.source                         out_ch
);
  import ppp_pkg::*;

  typedef struct packed {
    tag_t tag;
    logic zero;
    logic negx;
    logic negy;
    logic negz;
  } side_t;

  localparam int RW = WORD_BITS + 3;
  localparam logic signed [RW-1:0] RMAX = RW'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] RMIN = -RMAX - RW'(1);
  localparam logic [QBITS-1:0] QLIM = {1'b1, {WORD_BITS{1'b0}}};

  word_t x_scale, x_offset, y_scale, y_offset, depth_a, depth_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale  <= word_t'(64'sd1 <<< FRAC_BITS);
      x_offset <= '0;
      y_scale  <= word_t'(64'sd1 <<< FRAC_BITS);
      y_offset <= '0;
      depth_a  <= '0;
      depth_b  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_SCALE:  x_scale  <= cfg_data;
        REG_X_OFFSET: x_offset <= cfg_data;
        REG_Y_SCALE:  y_scale  <= cfg_data;
        REG_Y_OFFSET: y_offset <= cfg_data;
        REG_DEPTH_A:  depth_a  <= cfg_data;
        REG_DEPTH_B:  depth_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: input register
  logic v1;
  word_t px1, py1, pz1;
  tag_t tag1;
  // stage 2: products
  logic v2, zero2, wneg2;
  logic signed [MAG_BITS-1:0] prx, pry, prz;
  logic [WORD_BITS-1:0] d2;
  tag_t tag2;
  // stage 3: numerators
  logic v3;
  logic signed [MAG_BITS-1:0] nx, ny;
  logic signed [MAG_BITS:0] nz;
  logic [WORD_BITS-1:0] d3;
  logic zero3, wneg3;
  tag_t tag3;
  // stage 4: magnitudes
  logic v4;
  logic [MAG_BITS-1:0] mx, my, mz;
  logic [WORD_BITS-1:0] d4;
  side_t sd4;

  logic signed [MAG_BITS:0] db_sh;
  assign db_sh = $signed({{(WORD_BITS + 1 - FRAC_BITS){depth_b[WORD_BITS-1]}}, depth_b,
                          {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1   <= in_ch.eye_x;
      py1   <= in_ch.eye_y;
      pz1   <= in_ch.eye_z;
      tag1  <= in_ch.vertex_id;
      prx   <= x_scale * px1;
      pry   <= y_scale * py1;
      prz   <= depth_a * pz1;
      d2    <= pz1[WORD_BITS-1] ? WORD_BITS'(-pz1) : WORD_BITS'(pz1);
      zero2 <= (pz1 == '0);
      wneg2 <= !pz1[WORD_BITS-1] && (pz1 != '0);
      tag2  <= tag1;
      nx    <= prx;
      ny    <= pry;
      nz    <= {prz[MAG_BITS-1], prz} + db_sh;
      d3    <= d2;
      zero3 <= zero2;
      wneg3 <= wneg2;
      tag3  <= tag2;
      mx    <= nx[MAG_BITS-1] ? MAG_BITS'(-nx) : MAG_BITS'(nx);
      my    <= ny[MAG_BITS-1] ? MAG_BITS'(-ny) : MAG_BITS'(ny);
      mz    <= nz[MAG_BITS] ? MAG_BITS'(-nz) : MAG_BITS'(nz);
      d4    <= d3;
      sd4   <= '{tag: tag3, zero: zero3, negx: nx[MAG_BITS-1] ^ wneg3,
                 negy: ny[MAG_BITS-1] ^ wneg3, negz: nz[MAG_BITS] ^ wneg3};
    end
  end

  logic [QBITS-1:0] qx, qy, qz;
  logic ox, oy, oz;

  ppp_div_lane u_div_x (.clk(clk), .en(en), .mag(mx), .dvs(d4), .quot(qx), .ovf(ox));
  ppp_div_lane u_div_y (.clk(clk), .en(en), .mag(my), .dvs(d4), .quot(qy), .ovf(oy));
  ppp_div_lane u_div_z (.clk(clk), .en(en), .mag(mz), .dvs(d4), .quot(qz), .ovf(oz));

  side_t sd [0:DIV_LAT-1];
  logic  vd [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= sd4;
      for (int i = 1; i < DIV_LAT; i++) sd[i] <= sd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v4;
      for (int i = 1; i < DIV_LAT; i++) vd[i] <= vd[i-1];
    end
  end

  // clamp quotient, apply sign, subtract offset, saturate; msb is the clip flag
  function automatic logic [WORD_BITS:0] finish(input logic [QBITS-1:0] q,
                                                input logic ov, input logic neg,
                                                input word_t off);
    logic [QBITS-1:0] qc;
    logic signed [QBITS:0] sq;
    logic signed [RW-1:0] r;
    qc = (ov || q > QLIM) ? QLIM : q;
    sq = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    r  = RW'(sq) - RW'(off);
    if (r > RMAX) return {1'b1, RMAX[WORD_BITS-1:0]};
    if (r < RMIN) return {1'b1, RMIN[WORD_BITS-1:0]};
    return {1'b0, r[WORD_BITS-1:0]};
  endfunction

  logic [WORD_BITS:0] fx, fy, fz;
  side_t sl;
  assign sl = sd[DIV_LAT-1];
  assign fx = finish(qx, ox, sl.negx, x_offset);
  assign fy = finish(qy, oy, sl.negy, y_offset);
  assign fz = finish(qz, oz, sl.negz, '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= vd[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.vertex_tag <= sl.tag;
      out_ch.zero_w     <= sl.zero;
      out_ch.screen_x   <= sl.zero ? '0 : fx[WORD_BITS-1:0];
      out_ch.screen_y   <= sl.zero ? '0 : fy[WORD_BITS-1:0];
      out_ch.ndc_depth  <= sl.zero ? '0 : fz[WORD_BITS-1:0];
      out_ch.clipped    <= !sl.zero && (fx[WORD_BITS] || fy[WORD_BITS] || fz[WORD_BITS]);
    end
  end

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.zero_w |-> !out_ch.clipped && out_ch.screen_x == '0
      && out_ch.ndc_depth == '0)
    else $error("zero w word not forced to zero");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_ch.valid)
    else $error("output valid right after reset");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v4) && $stable(vd[DIV_LAT-1]))
    else $error("pipeline moved during stall");
endmodule
`default_nettype wire
